// ===== src/paged_memory_process_manager_assert.svh =====
// Assertion macros for the paged memory process manager.
`ifndef PAGED_MEMORY_PROCESS_MANAGER_ASSERT_SVH
`define PAGED_MEMORY_PROCESS_MANAGER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PMPM_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PMPM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/pmpm_pkg.sv =====
// Package: field widths, request and status codes, default geometry.
package pmpm_pkg;

    localparam int REQ_W  = 2;
    localparam int PROC_W = 8;
    localparam int CNT_W  = 7;
    localparam int ADDR_W = 14;
    localparam int DATA_W = 8;
    localparam int STS_W  = 2;

    typedef logic [REQ_W-1:0] t_req;
    typedef logic [STS_W-1:0] t_status;

    localparam t_req REQ_CREATE = 2'd0;
    localparam t_req REQ_KILL   = 2'd1;
    localparam t_req REQ_STORE  = 2'd2;
    localparam t_req REQ_LOAD   = 2'd3;

    localparam t_status STS_OK          = 2'd0;
    localparam t_status STS_NO_TABLE    = 2'd1;
    localparam t_status STS_NO_DATA     = 2'd2;
    localparam t_status STS_KILL_ABSENT = 2'd3;

    // Geometry defaults; page size and page count must be powers of two.
    localparam int DEF_PAGE_BYTES     = 256;
    localparam int DEF_PAGE_TOTAL     = 64;
    localparam int DEF_TABLE_PTR_BASE = 64;

endpackage

// ===== src/pmpm_if.sv =====
// Request and response channel interfaces.
interface pmpm_req_if;
    logic                        valid;
    logic                        ready;
    pmpm_pkg::t_req              req_type;
    logic [pmpm_pkg::PROC_W-1:0] proc_id;
    logic [pmpm_pkg::CNT_W-1:0]  alloc_pages;
    logic [pmpm_pkg::ADDR_W-1:0] virt_addr;
    logic [pmpm_pkg::DATA_W-1:0] write_data;

    modport source (output valid, req_type, proc_id, alloc_pages, virt_addr, write_data,
                    input ready);
    modport sink   (input valid, req_type, proc_id, alloc_pages, virt_addr, write_data,
                    output ready);
endinterface

interface pmpm_rsp_if;
    logic                        valid;
    logic                        ready;
    pmpm_pkg::t_status           status;
    logic [pmpm_pkg::ADDR_W-1:0] phys_addr;
    logic [pmpm_pkg::DATA_W-1:0] read_data;

    modport source (output valid, status, phys_addr, read_data, input ready);
    modport sink   (input valid, status, phys_addr, read_data, output ready);
endinterface

// ===== src/pmpm_mem.sv =====
// Byte-wide single-port physical memory with registered read.
module pmpm_mem #(
    parameter int DEPTH = pmpm_pkg::DEF_PAGE_BYTES * pmpm_pkg::DEF_PAGE_TOTAL,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic [AW-1:0]               i_addr,
    input  logic                        i_we,
    input  logic [pmpm_pkg::DATA_W-1:0] i_wdata,
    output logic [pmpm_pkg::DATA_W-1:0] o_rdata
);

    logic [pmpm_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [pmpm_pkg::DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/pmpm_agu.sv =====
// Shared address unit: page number and offset to physical byte address.
module pmpm_agu #(
    parameter int PAGE_BYTES = pmpm_pkg::DEF_PAGE_BYTES,
    parameter int PAGE_TOTAL = pmpm_pkg::DEF_PAGE_TOTAL,
    parameter int AW         = $clog2(PAGE_BYTES) + $clog2(PAGE_TOTAL)
) (
    input  logic [pmpm_pkg::DATA_W-1:0] i_page,
    input  logic [pmpm_pkg::ADDR_W-1:0] i_off,
    output logic [AW-1:0]               o_addr
);

    localparam int PB_W = $clog2(PAGE_BYTES);
    localparam int PT_W = $clog2(PAGE_TOTAL);

    // offset mod page size, page mod page count (wraps at memory size)
    assign o_addr = {i_page[PT_W-1:0], i_off[PB_W-1:0]};

endmodule

// ===== src/paged_memory_process_manager.sv =====
// Top level: paged memory process manager with page table walk sequencer.
//
// Usage:
//   i_req carries one request per valid/ready handshake: create, kill, store
//   byte or load byte for a process. o_rsp returns exactly one response per
//   request (status, translated address, load data), in request order.
//   i_req.ready is high only while the sequencer is idle; one request is
//   worked on at a time over one single-port byte memory.
// Sequencing: every memory access goes through the single memory port; a
//   kill walks every table entry, and a create scans the free map from
//   page 1 upward for each page it takes.
// Reset: a clearing pass writes every memory byte (16384 by default), one
//   byte per cycle, leaving byte 0 at one so page 0 is in use. No request
//   is taken until it finishes.
// Stall: the response sits in an output register; the next request is
//   accepted while it waits, but its own response waits for the slot.
`include "paged_memory_process_manager_assert.svh"

module paged_memory_process_manager #(
    parameter int PAGE_BYTES     = pmpm_pkg::DEF_PAGE_BYTES,
    parameter int PAGE_TOTAL     = pmpm_pkg::DEF_PAGE_TOTAL,
    parameter int TABLE_PTR_BASE = pmpm_pkg::DEF_TABLE_PTR_BASE
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pmpm_req_if.sink   i_req,
    pmpm_rsp_if.source o_rsp
);

    localparam int PB_W      = $clog2(PAGE_BYTES);
    localparam int PT_W      = $clog2(PAGE_TOTAL);
    localparam int AW        = PB_W + PT_W;
    localparam int DEPTH     = PAGE_BYTES * PAGE_TOTAL;
    localparam int VA_W      = pmpm_pkg::ADDR_W;
    localparam int DW        = pmpm_pkg::DATA_W;
    localparam logic [DW-1:0] LAST_PAGE = DW'(PAGE_TOTAL - 1);

    // sequencer states
    localparam logic [4:0] ST_CLEAR  = 5'd0;
    localparam logic [4:0] ST_IDLE   = 5'd1;
    localparam logic [4:0] ST_C_RD   = 5'd2;   // create: read free map byte
    localparam logic [4:0] ST_C_CHK  = 5'd3;   // create: test and claim
    localparam logic [4:0] ST_C_SLOT = 5'd4;   // create: write table pointer
    localparam logic [4:0] ST_C_ENT  = 5'd5;   // create: write table entry
    localparam logic [4:0] ST_K_RD   = 5'd6;   // kill: read table pointer
    localparam logic [4:0] ST_K_CHK  = 5'd7;   // kill: test, clear pointer
    localparam logic [4:0] ST_KE_RD  = 5'd8;   // kill: read table entry
    localparam logic [4:0] ST_KE_CHK = 5'd9;   // kill: clear table entry
    localparam logic [4:0] ST_K_FREE = 5'd10;  // kill: free data page
    localparam logic [4:0] ST_K_TAB  = 5'd11;  // kill: free table page
    localparam logic [4:0] ST_T_RD   = 5'd12;  // translate: read pointer
    localparam logic [4:0] ST_T_TAB  = 5'd13;  // translate: read entry
    localparam logic [4:0] ST_T_PG   = 5'd14;  // translate: access byte
    localparam logic [4:0] ST_T_LD   = 5'd15;  // load data back
    localparam logic [4:0] ST_DONE   = 5'd16;

    logic [4:0]              r_state,  n_state;
    logic [AW-1:0]           r_clr,    n_clr;
    pmpm_pkg::t_req          r_type,   n_type;
    logic [DW-1:0]           r_proc,   n_proc;
    logic [pmpm_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [VA_W-1:0]         r_vaddr,  n_vaddr;
    logic [DW-1:0]           r_wdata,  n_wdata;
    logic [DW-1:0]           r_table,  n_table;
    logic [DW-1:0]           r_pg,     n_pg;
    logic [DW-1:0]           r_p,      n_p;
    logic [DW-1:0]           r_i,      n_i;
    logic                    r_data_ph, n_data_ph;
    pmpm_pkg::t_status       r_status, n_status;
    logic [VA_W-1:0]         r_paddr,  n_paddr;
    logic [DW-1:0]           r_rd,     n_rd;
    logic                    r_ovalid, n_ovalid;
    pmpm_pkg::t_status       r_o_status, n_o_status;
    logic [VA_W-1:0]         r_o_paddr,  n_o_paddr;
    logic [DW-1:0]           r_o_rd,     n_o_rd;

    logic [DW-1:0]   agu_page;
    logic [VA_W-1:0] agu_off;
    logic [AW-1:0]   agu_addr;
    logic [AW-1:0]   mem_addr;
    logic            mem_we;
    logic [DW-1:0]   mem_wdata;
    logic [DW-1:0]   mem_rdata;
    logic [VA_W-1:0] slot_off;
    logic [VA_W-1:0] vpage;
    logic [DW-1:0]   i_next;

    pmpm_agu #(
        .PAGE_BYTES (PAGE_BYTES),
        .PAGE_TOTAL (PAGE_TOTAL),
        .AW         (AW)
    ) u_agu (
        .i_page (agu_page),
        .i_off  (agu_off),
        .o_addr (agu_addr)
    );

    pmpm_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_addr  (mem_addr),
        .i_we    (mem_we),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // pointer slot offset wraps within page 0 (agu keeps the low bits)
    assign slot_off = VA_W'(TABLE_PTR_BASE) + VA_W'(r_proc);
    assign vpage    = r_vaddr >> PB_W;
    assign i_next   = r_i + 1'b1;
    assign mem_addr = (r_state == ST_CLEAR) ? r_clr : agu_addr;

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_type     = r_type;
        n_proc     = r_proc;
        n_cnt      = r_cnt;
        n_vaddr    = r_vaddr;
        n_wdata    = r_wdata;
        n_table    = r_table;
        n_pg       = r_pg;
        n_p        = r_p;
        n_i        = r_i;
        n_data_ph  = r_data_ph;
        n_status   = r_status;
        n_paddr    = r_paddr;
        n_rd       = r_rd;
        n_ovalid   = r_ovalid;
        n_o_status = r_o_status;
        n_o_paddr  = r_o_paddr;
        n_o_rd     = r_o_rd;
        agu_page   = '0;
        agu_off    = '0;
        mem_we     = 1'b0;
        mem_wdata  = '0;

        if (r_ovalid && o_rsp.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = (r_clr == '0) ? DW'(1) : '0;
                n_clr     = r_clr + 1'b1;
                if (&r_clr) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_type    = i_req.req_type;
                    n_proc    = i_req.proc_id;
                    n_cnt     = i_req.alloc_pages;
                    n_vaddr   = i_req.virt_addr;
                    n_wdata   = i_req.write_data;
                    n_status  = pmpm_pkg::STS_OK;
                    n_paddr   = '0;
                    n_rd      = '0;
                    n_p       = DW'(1);
                    n_i       = '0;
                    n_data_ph = 1'b0;
                    unique case (i_req.req_type)
                        pmpm_pkg::REQ_CREATE: n_state = ST_C_RD;
                        pmpm_pkg::REQ_KILL:   n_state = ST_K_RD;
                        default:              n_state = ST_T_RD;
                    endcase
                end
            end
            ST_C_RD: begin
                agu_off = VA_W'(r_p);
                n_state = ST_C_CHK;
            end
            ST_C_CHK: begin
                agu_off = VA_W'(r_p);
                if (mem_rdata == '0) begin
                    mem_we    = 1'b1;
                    mem_wdata = DW'(1);
                    if (!r_data_ph) begin
                        n_table = r_p;
                        n_state = ST_C_SLOT;
                    end else begin
                        n_pg    = r_p;
                        n_state = ST_C_ENT;
                    end
                end else if (r_p == LAST_PAGE) begin
                    n_status = r_data_ph ? pmpm_pkg::STS_NO_DATA : pmpm_pkg::STS_NO_TABLE;
                    n_state  = ST_DONE;
                end else begin
                    n_p     = r_p + 1'b1;
                    n_state = ST_C_RD;
                end
            end
            ST_C_SLOT: begin
                agu_off   = slot_off;
                mem_we    = 1'b1;
                mem_wdata = r_table;
                if (r_cnt == '0) begin
                    n_state = ST_DONE;
                end else begin
                    n_p       = DW'(1);
                    n_data_ph = 1'b1;
                    n_state   = ST_C_RD;
                end
            end
            ST_C_ENT: begin
                agu_page  = r_table;
                agu_off   = VA_W'(r_i);
                mem_we    = 1'b1;
                mem_wdata = r_pg;
                n_i       = i_next;
                if (i_next == DW'(r_cnt)) begin
                    n_state = ST_DONE;
                end else begin
                    n_p     = DW'(1);
                    n_state = ST_C_RD;
                end
            end
            ST_K_RD: begin
                agu_off = slot_off;
                n_state = ST_K_CHK;
            end
            ST_K_CHK: begin
                agu_off = slot_off;
                if (mem_rdata == '0) begin
                    n_status = pmpm_pkg::STS_KILL_ABSENT;
                    n_state  = ST_DONE;
                end else begin
                    mem_we  = 1'b1;
                    n_table = mem_rdata;
                    n_i     = '0;
                    n_state = ST_KE_RD;
                end
            end
            ST_KE_RD: begin
                agu_page = r_table;
                agu_off  = VA_W'(r_i);
                n_state  = ST_KE_CHK;
            end
            ST_KE_CHK: begin
                agu_page = r_table;
                agu_off  = VA_W'(r_i);
                mem_we   = 1'b1;
                n_pg     = mem_rdata;
                if (mem_rdata != '0) begin
                    n_state = ST_K_FREE;
                end else if (r_i == LAST_PAGE) begin
                    n_state = ST_K_TAB;
                end else begin
                    n_i     = i_next;
                    n_state = ST_KE_RD;
                end
            end
            ST_K_FREE: begin
                // any nonzero entry frees its map byte, even past the map
                agu_off = VA_W'(r_pg);
                mem_we  = 1'b1;
                if (r_i == LAST_PAGE) begin
                    n_state = ST_K_TAB;
                end else begin
                    n_i     = i_next;
                    n_state = ST_KE_RD;
                end
            end
            ST_K_TAB: begin
                agu_off = VA_W'(r_table);
                mem_we  = 1'b1;
                n_state = ST_DONE;
            end
            ST_T_RD: begin
                agu_off = slot_off;
                n_state = ST_T_TAB;
            end
            ST_T_TAB: begin
                // no table: pointer reads zero, walk goes through page 0
                agu_page = mem_rdata;
                agu_off  = vpage;
                n_state  = ST_T_PG;
            end
            ST_T_PG: begin
                agu_page = mem_rdata;
                agu_off  = r_vaddr;
                n_paddr  = VA_W'(agu_addr);
                if (r_type == pmpm_pkg::REQ_STORE) begin
                    mem_we    = 1'b1;
                    mem_wdata = r_wdata;
                    n_state   = ST_DONE;
                end else begin
                    n_state = ST_T_LD;
                end
            end
            ST_T_LD: begin
                n_rd    = mem_rdata;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid   = 1'b1;
                    n_o_status = r_status;
                    n_o_paddr  = r_paddr;
                    n_o_rd     = r_rd;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_type     <= n_type;
        r_proc     <= n_proc;
        r_cnt      <= n_cnt;
        r_vaddr    <= n_vaddr;
        r_wdata    <= n_wdata;
        r_table    <= n_table;
        r_pg       <= n_pg;
        r_p        <= n_p;
        r_i        <= n_i;
        r_data_ph  <= n_data_ph;
        r_status   <= n_status;
        r_paddr    <= n_paddr;
        r_rd       <= n_rd;
        r_o_status <= n_o_status;
        r_o_paddr  <= n_o_paddr;
        r_o_rd     <= n_o_rd;
    end

    assign i_req.ready     = (r_state == ST_IDLE);
    assign o_rsp.valid     = r_ovalid;
    assign o_rsp.status    = r_o_status;
    assign o_rsp.phys_addr = r_o_paddr;
    assign o_rsp.read_data = r_o_rd;

    `PMPM_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, i_req.valid && i_req.ready, (r_state != ST_IDLE) && (r_state != ST_CLEAR), "accepted request did not start the sequencer")
    `PMPM_ASSERT_NOW(a_clear_quiet, i_clk, i_rst_n, r_state == ST_CLEAR, !o_rsp.valid && !i_req.ready, "channel active during clearing pass")
    `PMPM_ASSERT_NOW(a_scan_from_one, i_clk, i_rst_n, (r_state == ST_C_RD) || (r_state == ST_C_CHK), (r_p != '0) && (r_p <= LAST_PAGE), "free map scan out of range")
    `PMPM_ASSERT_NOW(a_kill_bound, i_clk, i_rst_n, (r_state == ST_KE_RD) || (r_state == ST_K_FREE), r_i <= LAST_PAGE, "kill walk past last table entry")
    `PMPM_ASSERT_NEXT(a_done_delivers, i_clk, i_rst_n, (r_state == ST_DONE) && (!r_ovalid || o_rsp.ready), o_rsp.valid && (r_state == ST_IDLE), "finished request not moved to output")

endmodule

// ===== bench/pmpm_checker.sv =====
// Response checker: predicts every response of the paged memory process manager.
module pmpm_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    pmpm_req_if  i_req,
    pmpm_rsp_if  i_rsp,
    output int   o_fail_count,
    output int   o_outstanding
);

    localparam int PAGE_BYTES     = pmpm_pkg::DEF_PAGE_BYTES;
    localparam int PAGE_TOTAL     = pmpm_pkg::DEF_PAGE_TOTAL;
    localparam int TABLE_PTR_BASE = pmpm_pkg::DEF_TABLE_PTR_BASE;
    localparam int MEM_BYTES      = PAGE_BYTES * PAGE_TOTAL;
    localparam int PROC_W         = pmpm_pkg::PROC_W;
    localparam int CNT_W          = pmpm_pkg::CNT_W;
    localparam int ADDR_W         = pmpm_pkg::ADDR_W;
    localparam int DATA_W         = pmpm_pkg::DATA_W;

    typedef struct packed {
        pmpm_pkg::t_status   status;
        logic [ADDR_W-1:0]   phys_addr;
        logic [DATA_W-1:0]   read_data;
    } t_rsp_fields;

    t_rsp_fields       pending_rsp_q[$];
    logic [DATA_W-1:0] model_mem [MEM_BYTES];
    int                mismatch_total = 0;

    // Byte address of (page, offset); offset stays in page, result wraps the store.
    function automatic logic [ADDR_W-1:0] mem_index(input int unsigned page,
                                                    input int unsigned offset);
        return ADDR_W'((page * PAGE_BYTES + offset % PAGE_BYTES) % MEM_BYTES);
    endfunction

    // First free page from 1 upward, marked used; 0 when the map is full.
    function automatic logic [7:0] claim_free_page();
        for (int p = 1; p < PAGE_TOTAL; p++) begin
            if (model_mem[mem_index(0, p)] == '0) begin
                model_mem[mem_index(0, p)] = 8'd1;
                return 8'(p);
            end
        end
        return 8'd0;
    endfunction

    function automatic logic [ADDR_W-1:0] translate_addr(input logic [PROC_W-1:0] proc,
                                                         input logic [ADDR_W-1:0] vaddr);
        logic [7:0] table_pg;
        logic [7:0] data_pg;
        table_pg = model_mem[mem_index(0, TABLE_PTR_BASE + proc)];
        data_pg  = model_mem[mem_index(table_pg, vaddr / PAGE_BYTES)];
        return mem_index(data_pg, vaddr % PAGE_BYTES);
    endfunction

    function automatic t_rsp_fields predict_response(input pmpm_pkg::t_req kind,
                                                     input logic [PROC_W-1:0] proc,
                                                     input logic [CNT_W-1:0] count,
                                                     input logic [ADDR_W-1:0] vaddr,
                                                     input logic [DATA_W-1:0] wdata);
        t_rsp_fields       r;
        logic [7:0]        table_pg;
        logic [7:0]        pg;
        logic [ADDR_W-1:0] sa;
        logic [ADDR_W-1:0] ea;
        r = '0;
        case (kind)
            pmpm_pkg::REQ_CREATE: begin
                table_pg = claim_free_page();
                if (table_pg == 0) begin
                    r.status = pmpm_pkg::STS_NO_TABLE;
                end else begin
                    model_mem[mem_index(0, TABLE_PTR_BASE + proc)] = table_pg;
                    // earlier pages stay taken when the map runs dry
                    for (int i = 0; i < count && r.status == pmpm_pkg::STS_OK; i++) begin
                        pg = claim_free_page();
                        if (pg == 0)
                            r.status = pmpm_pkg::STS_NO_DATA;
                        else
                            model_mem[mem_index(table_pg, i)] = pg;
                    end
                end
            end
            pmpm_pkg::REQ_KILL: begin
                sa       = mem_index(0, TABLE_PTR_BASE + proc);
                table_pg = model_mem[sa];
                if (table_pg == 0) begin
                    r.status = pmpm_pkg::STS_KILL_ABSENT;
                end else begin
                    model_mem[sa] = '0;
                    for (int i = 0; i < PAGE_TOTAL; i++) begin
                        ea            = mem_index(table_pg, i);
                        pg            = model_mem[ea];
                        model_mem[ea] = '0;
                        if (pg != 0)
                            model_mem[mem_index(0, pg)] = '0;
                    end
                    model_mem[mem_index(0, table_pg)] = '0;
                end
            end
            pmpm_pkg::REQ_STORE: begin
                r.phys_addr              = translate_addr(proc, vaddr);
                model_mem[r.phys_addr]   = wdata;
            end
            pmpm_pkg::REQ_LOAD: begin
                r.phys_addr = translate_addr(proc, vaddr);
                r.read_data = model_mem[r.phys_addr];
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_rsp_fields want;
        t_rsp_fields got;
        if (!i_rst_n) begin
            for (int a = 0; a < MEM_BYTES; a++)
                model_mem[a] = '0;
            model_mem[0] = 8'd1;
            pending_rsp_q.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                got.status    = i_rsp.status;
                got.phys_addr = i_rsp.phys_addr;
                got.read_data = i_rsp.read_data;
                if (pending_rsp_q.size() == 0) begin
                    mismatch_total++;
                    $display("%0t: unexpected response, expected none, actual %0d/%0d/%0d",
                             $time, got.status, got.phys_addr, got.read_data);
                end else begin
                    want = pending_rsp_q.pop_front();
                    if (got.status !== want.status) begin
                        mismatch_total++;
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, got.status);
                    end
                    if (got.phys_addr !== want.phys_addr) begin
                        mismatch_total++;
                        $display("%0t: phys_addr mismatch, expected %0d, actual %0d",
                                 $time, want.phys_addr, got.phys_addr);
                    end
                    if (got.read_data !== want.read_data) begin
                        mismatch_total++;
                        $display("%0t: read_data mismatch, expected %0d, actual %0d",
                                 $time, want.read_data, got.read_data);
                    end
                end
            end
            if (i_req.valid && i_req.ready)
                pending_rsp_q.push_back(predict_response(i_req.req_type, i_req.proc_id,
                                                         i_req.alloc_pages, i_req.virt_addr,
                                                         i_req.write_data));
        end
        o_outstanding <= pending_rsp_q.size();
        o_fail_count  <= mismatch_total;
    end

endmodule

// ===== bench/tb.sv =====
// Testbench top: request stimulus, response back-pressure and verdict.
module tb;

    localparam int PROC_W           = pmpm_pkg::PROC_W;
    localparam int CNT_W            = pmpm_pkg::CNT_W;
    localparam int ADDR_W           = pmpm_pkg::ADDR_W;
    localparam int DATA_W           = pmpm_pkg::DATA_W;
    localparam int PROC_SLOTS       = 192;    // legal process numbers 0..191
    localparam int RANDOM_ITEMS     = 1330;
    localparam int DRAIN_EVERY      = 200;    // sender waits for all responses this often
    localparam int HOLD_AT_RESPONSE = 500;    // response count that starts the long stall
    localparam int LONG_HOLD_CYCLES = 800;
    // Clearing pass or a worst-case create plus the long stall, with margin.
    localparam int WATCHDOG_LIMIT   = 60000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   outstanding;

    pmpm_req_if req_ch();
    pmpm_rsp_if rsp_ch();

    paged_memory_process_manager dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    pmpm_checker rsp_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_req         (req_ch),
        .i_rsp         (rsp_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // Stimulus-side view of the allocator: which processes own a table and how
    // many data pages they got. Only used to aim stores and loads at mapped
    // pages; stale table bytes can make it drift, which the checker tolerates.
    bit proc_live  [PROC_SLOTS];
    int proc_pages [PROC_SLOTS];
    int live_q[$];
    int free_pages;
    int sent_count;
    int last_store_proc;
    int last_store_addr;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Track what an accepted request did to the allocator.
    function automatic void note_accepted(input pmpm_pkg::t_req kind, input int proc,
                                          input int count);
        int kept[$];
        int taken;
        if (kind == pmpm_pkg::REQ_CREATE && free_pages > 0) begin
            // table page first, then as many data pages as remain
            free_pages--;
            taken       = (count < free_pages) ? count : free_pages;
            free_pages -= taken;
            if (!proc_live[proc])
                live_q.push_back(proc);
            proc_live[proc]  = 1'b1;     // a create over a live process leaks the old pages
            proc_pages[proc] = taken;
        end else if (kind == pmpm_pkg::REQ_KILL && proc_live[proc]) begin
            free_pages     += 1 + proc_pages[proc];
            proc_live[proc] = 1'b0;
            foreach (live_q[k])
                if (live_q[k] != proc)
                    kept.push_back(live_q[k]);
            live_q = kept;
        end
    endfunction

    // Offer one request after a random gap; returns at the accepting edge with
    // valid still high, so back-to-back requests never toggle it within a step.
    task automatic send_request(input pmpm_pkg::t_req kind, input int proc, input int count,
                                input int vaddr, input int wdata);
        int gap;
        gap = (sent_count % 150 < 30) ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= kind;
        req_ch.proc_id     <= proc[PROC_W-1:0];
        req_ch.alloc_pages <= count[CNT_W-1:0];
        req_ch.virt_addr   <= vaddr[ADDR_W-1:0];
        req_ch.write_data  <= wdata[DATA_W-1:0];
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        sent_count++;
        note_accepted(kind, proc, count);
        if (kind == pmpm_pkg::REQ_STORE) begin
            last_store_proc = proc;
            last_store_addr = vaddr;
        end
    endtask

    // Hold the request side idle until every response is back.
    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        @(posedge clk);    // checker count is a registered copy of its queue size
        while (outstanding != 0) @(posedge clk);
    endtask

    function automatic int pick_idle_proc();
        int p;
        do p = $urandom_range(0, PROC_SLOTS - 1); while (proc_live[p]);
        return p;
    endfunction

    task automatic issue_random_request();
        int pick;
        int p;
        int count;
        int vpage;
        int offset;
        pick = $urandom_range(0, 99);
        // nearly out of pages: lean toward kills so creates keep succeeding
        if (free_pages < 4 && live_q.size() > 0 && pick < 50)
            pick = 25;
        if (live_q.size() == 0 || pick < 18) begin
            if (pick < 2 && live_q.size() > 0) begin
                // create over a live process, small so the leak stays small
                p     = live_q[$urandom_range(0, live_q.size() - 1)];
                count = $urandom_range(0, 2);
            end else begin
                p     = pick_idle_proc();
                count = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 64)
                                                    : $urandom_range(0, 6);
            end
            send_request(pmpm_pkg::REQ_CREATE, p, count, $urandom_range(0, 16383),
                         $urandom_range(0, 255));
        end else if (pick < 32) begin
            p = (pick < 30) ? live_q[$urandom_range(0, live_q.size() - 1)] : pick_idle_proc();
            send_request(pmpm_pkg::REQ_KILL, p, $urandom_range(0, 64),
                         $urandom_range(0, 16383), $urandom_range(0, 255));
        end else if (pick < 37) begin
            // stray load: any process, any address; loads change nothing
            send_request(pmpm_pkg::REQ_LOAD, $urandom_range(0, PROC_SLOTS - 1),
                         $urandom_range(0, 64), $urandom_range(0, 16383),
                         $urandom_range(0, 255));
        end else if (pick < 39) begin
            // store without a table: goes through page 0 to page 1, kept above the
            // first 64 bytes so no table entry is hit
            send_request(pmpm_pkg::REQ_STORE, pick_idle_proc(), $urandom_range(0, 64),
                         $urandom_range(64, 255), $urandom_range(0, 255));
        end else begin
            p = live_q[$urandom_range(0, live_q.size() - 1)];
            if (proc_pages[p] == 0) begin
                send_request(pmpm_pkg::REQ_LOAD, p, 0, $urandom_range(0, 255), 0);
            end else begin
                vpage  = $urandom_range(0, proc_pages[p] - 1);
                // mostly above byte 63, so freed data pages rarely leave
                // stale entries when reused as a table page
                offset = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(64, 255);
                if (pick < 70)
                    send_request(pmpm_pkg::REQ_STORE, p, $urandom_range(0, 64),
                                 vpage * 256 + offset, $urandom_range(0, 255));
                else if (pick < 85 && last_store_proc >= 0 && proc_live[last_store_proc])
                    send_request(pmpm_pkg::REQ_LOAD, last_store_proc, 0, last_store_addr, 0);
                else
                    send_request(pmpm_pkg::REQ_LOAD, p, 0, vpage * 256 + offset,
                                 $urandom_range(0, 255));
            end
        end
    endtask

    // Response side: random stalls per response, idle-free stretches, and one
    // long hold so the output register fills and the input backs up.
    initial begin
        int gap;
        int rsp_taken;
        rsp_taken = 0;
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        forever begin
            if (rsp_taken == HOLD_AT_RESPONSE) begin
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                gap = 0;
            end else begin
                gap = (rsp_taken % 170 < 35) ? 0 : $urandom_range(0, 19);
            end
            if (gap > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid) @(posedge clk);
            rsp_taken++;
        end
    end

    // Watchdog: too long with no request or response moving ends the run.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin
        rst_n              <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= pmpm_pkg::REQ_CREATE;
        req_ch.proc_id     <= '0;
        req_ch.alloc_pages <= '0;
        req_ch.virt_addr   <= '0;
        req_ch.write_data  <= '0;
        free_pages      = pmpm_pkg::DEF_PAGE_TOTAL - 1;
        sent_count      = 0;
        last_store_proc = -1;
        last_store_addr = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        // The block runs its clearing pass now; the first handshake waits for it.

        // ---- directed part ----
        // No table yet: translation goes through page 0 (map byte 0 -> page 1).
        send_request(pmpm_pkg::REQ_LOAD, 0, 0, 0, 0);
        send_request(pmpm_pkg::REQ_KILL, 5, 0, 0, 0);        // kill of an absent process
        send_request(pmpm_pkg::REQ_CREATE, 0, 0, 0, 0);      // table page 1, no data
        send_request(pmpm_pkg::REQ_CREATE, 191, 3, 0, 0);    // highest pointer slot, byte 255
        send_request(pmpm_pkg::REQ_STORE, 191, 0, 0, 8'hFF);
        send_request(pmpm_pkg::REQ_STORE, 191, 0, 2 * 256 + 255, 8'h5A);
        send_request(pmpm_pkg::REQ_LOAD, 191, 0, 0, 0);
        send_request(pmpm_pkg::REQ_LOAD, 191, 0, 2 * 256 + 255, 0);
        // Tableless store lands in page 1 = process 0's table, entry 5 := 200,
        // a page number beyond the map.
        send_request(pmpm_pkg::REQ_STORE, 20, 0, 5, 200);
        // Process 0 now maps page 5 to page 200: address wraps the store.
        send_request(pmpm_pkg::REQ_LOAD, 0, 0, 5 * 256 + 17, 0);
        // Widest create: takes every remaining page and fails on data.
        send_request(pmpm_pkg::REQ_CREATE, 7, 64, 0, 0);
        send_request(pmpm_pkg::REQ_CREATE, 8, 1, 0, 0);      // no page left for a table
        send_request(pmpm_pkg::REQ_STORE, 7, 0, 56 * 256 + 128, 8'hA5);
        send_request(pmpm_pkg::REQ_LOAD, 7, 0, 56 * 256 + 128, 0);
        send_request(pmpm_pkg::REQ_KILL, 7, 0, 0, 0);
        send_request(pmpm_pkg::REQ_CREATE, 191, 2, 0, 0);    // over a live process: leak
        send_request(pmpm_pkg::REQ_KILL, 0, 0, 0, 0);        // walks the out-of-map entry
        send_request(pmpm_pkg::REQ_KILL, 191, 0, 0, 0);
        send_request(pmpm_pkg::REQ_LOAD, 100, 0, 16383, 0);
        // Tableless store into page 0 byte 200 (slot of an absent process).
        send_request(pmpm_pkg::REQ_STORE, 150, 0, 63 * 256 + 200, 8'h00);
        drain_responses();

        // ---- random part ----
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            issue_random_request();
            if (n % DRAIN_EVERY == DRAIN_EVERY - 1)
                drain_responses();
        end

        drain_responses();
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
